// File: src/wclb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wclb_pkg: shared types and constants of the wide character line buffer
// Cell kinds, command codes, register indexes, item structs and the FSM states.
// ----------------------------------------------------------------------------
package wclb_pkg;

	localparam int MAX_COLUMNS_DEF = 128;

	localparam logic [7:0]  BLANK_CODE = 8'h20;
	localparam logic [15:0] WIDE_SPACE = 16'h8140;
	localparam logic [7:0]  CARET      = 8'h5E;
	localparam logic [7:0]  AT_SIGN    = 8'h40;
	localparam logic [7:0]  BS_CODE    = 8'h08;
	localparam logic [7:0]  FF_CODE    = 8'h0C;

	localparam logic [7:0] RST_WIDTH = 8'd80;
	localparam logic [7:0] RST_ATTR  = 8'd7;

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_FIRST  = 2'd1,
		KIND_SECOND = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CMD_PUT   = 3'd0,
		CMD_SETC  = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_ERASE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_NATTR  = 2'd1,
		REG_WSATTR = 2'd2,
		REG_DISPEN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] code;
		logic [7:0]  column;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cursor_col;
		logic [7:0] cell_code;
		logic [7:0] cell_attr;
		logic [1:0] cell_kind;
		logic       lead_pending;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,    // wait for start
		ST_DISP,    // decode item, start a character, sweep, read or finish
		ST_RD1,     // kind reads of col, then col+1 issued
		ST_RD2,
		ST_PLAN,    // decide writes for one character or an erase
		ST_WR,      // write planned cells one per cycle
		ST_SWEEP,   // blank a range one cell per cycle
		ST_RDCELL,  // wait for cell read
		ST_DONE     // present result
	} state_t;

endpackage
`default_nettype wire

// File: src/wide_char_line_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wide_char_line_buffer: one-line character-cell buffer with wide characters
// Cells live in one synchronous RAM; a sequencer reads kinds and writes cells.
// ----------------------------------------------------------------------------
// One item is taken while busy is low and gives exactly one result strobe.
// Cells are kept in a simple dual-port style RAM (one write, one registered read a
// cycle); a character takes kind reads at the cursor and the next column, then up
// to four cell writes, and a control code is shown as a caret pair that goes
// through these steps twice. Clear and erase blank their columns in a sweep. Set
// cursor and unused commands go from decode straight to the result. The result
// strobe cannot be held off.
// At reset the RAM is not swept; a valid bit per column makes unwritten cells
// read as blanks with the reset attribute.
module wide_char_line_buffer #(
	parameter int MAX_COLUMNS = wclb_pkg::MAX_COLUMNS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wclb_pkg::in_item_t  item,
	output logic                done,
	output wclb_pkg::out_item_t result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [7:0]          cfg_data
);
	localparam int AW = $clog2(MAX_COLUMNS);
	localparam logic [9:0] MAXC = 10'(MAX_COLUMNS);

	// config registers
	logic [7:0] width_q, nattr_q, wsattr_q;
	logic       dispen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= wclb_pkg::RST_WIDTH;
			nattr_q  <= wclb_pkg::RST_ATTR;
			wsattr_q <= wclb_pkg::RST_ATTR;
			dispen_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (wclb_pkg::reg_idx_t'(cfg_index))
				wclb_pkg::REG_WIDTH:  width_q  <= cfg_data;
				wclb_pkg::REG_NATTR:  nattr_q  <= cfg_data;
				wclb_pkg::REG_WSATTR: wsattr_q <= cfg_data;
				wclb_pkg::REG_DISPEN: dispen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [9:0] w_eff;
	always_comb begin
		if (width_q == 8'd0) w_eff = 10'd1;
		else if ({2'b0, width_q} > MAXC) w_eff = MAXC;
		else w_eff = {2'b0, width_q};
	end

	// cell RAM: {code, attr, kind}
	logic [17:0] mem [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] vld_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [17:0]   wr_data, rd_raw_s1;
	logic          rd_vld_s1;
	logic [17:0]   rd_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_raw_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			if (rd_en) rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_raw_s1
		: {wclb_pkg::BLANK_CODE, wclb_pkg::RST_ATTR, wclb_pkg::KIND_SINGLE};

	// sequencer state
	wclb_pkg::state_t state_q, state_d;
	logic [7:0]  cursor_q, cursor_d;
	logic [7:0]  lead_q, lead_d;
	wclb_pkg::in_item_t item_q, item_d;
	logic        caret_q, caret_d;    // second half of caret pair pending
	logic [7:0]  ch_q, ch_d;          // current character low byte
	logic        wide_q, wide_d;      // current character is wide
	logic [15:0] wcode_q, wcode_d;
	logic [1:0]  k0_q, k0_d;          // kind at col
	// write plan: up to four writes
	logic [3:0]  wv_q, wv_d;
	logic [9:0]  wa_q [4];
	logic [9:0]  wa_d [4];
	logic [17:0] wd_q [4];
	logic [17:0] wd_d [4];
	logic [9:0]  sw_q, sw_d;          // sweep pointer
	logic [9:0]  swe_q, swe_d;        // sweep end
	wclb_pkg::out_item_t res_q, res_d;
	logic        done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wclb_pkg::ST_IDLE;
			cursor_q <= '0;
			lead_q   <= '0;
			caret_q  <= 1'b0;
			wv_q     <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			lead_q   <= lead_d;
			caret_q  <= caret_d;
			wv_q     <= wv_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q  <= item_d;
		ch_q    <= ch_d;
		wide_q  <= wide_d;
		wcode_q <= wcode_d;
		k0_q    <= k0_d;
		wa_q    <= wa_d;
		wd_q    <= wd_d;
		sw_q    <= sw_d;
		swe_q   <= swe_d;
		res_q   <= res_d;
	end

	assign busy   = (state_q != wclb_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	logic [9:0] col;
	logic [17:0] blank;
	logic [8:0]  adv1, adv2;
	logic        lead_byte;
	logic [2:0]  widx;
	assign col   = {2'b0, cursor_q};
	assign blank = {wclb_pkg::BLANK_CODE, nattr_q, wclb_pkg::KIND_SINGLE};
	assign adv1  = {1'b0, cursor_q} + 9'd1;
	assign adv2  = {1'b0, cursor_q} + 9'd2;
	assign lead_byte = (ch_q >= 8'h81 && ch_q <= 8'h9F) || (ch_q >= 8'hE0 && ch_q <= 8'hFC);

	always_comb begin
		state_d = state_q;
		cursor_d = cursor_q;
		lead_d = lead_q;
		item_d = item_q;
		caret_d = caret_q;
		ch_d = ch_q;
		wide_d = wide_q;
		wcode_d = wcode_q;
		k0_d = k0_q;
		wv_d = wv_q;
		wa_d = wa_q;
		wd_d = wd_q;
		sw_d = sw_q;
		swe_d = swe_q;
		res_d = res_q;
		done_d = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = blank;
		widx = 3'd0;

		unique case (state_q)
			wclb_pkg::ST_IDLE: begin
				if (start) begin
					item_d = item;
					caret_d = 1'b0;
					state_d = wclb_pkg::ST_DISP;
				end
			end
			wclb_pkg::ST_DISP: begin
				state_d = wclb_pkg::ST_DONE;
				case (item_q.cmd)
					wclb_pkg::CMD_PUT: begin
						if (caret_q) begin
							// second of a caret pair
							ch_d = item_q.code[7:0] + wclb_pkg::AT_SIGN;
							wide_d = (lead_q != 8'd0);
							wcode_d = {lead_q, item_q.code[7:0] + wclb_pkg::AT_SIGN};
							caret_d = 1'b0;
							state_d = wclb_pkg::ST_RD1;
						end else if (item_q.code == {8'd0, wclb_pkg::BS_CODE}) begin
							if (cursor_q != 8'd0) cursor_d = cursor_q - 8'd1;
						end else if (item_q.code == {8'd0, wclb_pkg::FF_CODE}) begin
							cursor_d = (cursor_q == 8'hFF) ? 8'hFF : adv1[7:0];
						end else if (item_q.code < 16'h0020) begin
							caret_d = 1'b1;
							ch_d = wclb_pkg::CARET;
							wide_d = (lead_q != 8'd0);
							wcode_d = {lead_q, wclb_pkg::CARET};
							state_d = wclb_pkg::ST_RD1;
						end else begin
							ch_d = item_q.code[7:0];
							wide_d = (lead_q != 8'd0) || (item_q.code[15:8] != 8'd0);
							wcode_d = (lead_q != 8'd0) ? {lead_q, item_q.code[7:0]}
								: item_q.code;
							state_d = wclb_pkg::ST_RD1;
						end
					end
					wclb_pkg::CMD_SETC: cursor_d = item_q.column;
					wclb_pkg::CMD_CLEAR: begin
						lead_d = '0;
						cursor_d = '0;
						sw_d = '0;
						swe_d = dispen_q ? w_eff : 10'd0;
						state_d = wclb_pkg::ST_SWEEP;
					end
					wclb_pkg::CMD_ERASE: begin
						if (col <= w_eff) begin
							// fetch kinds, then sweep col..w-1
							ch_d = 8'd0;
							state_d = wclb_pkg::ST_RD1;
						end
					end
					wclb_pkg::CMD_READ: begin
						if ({2'b0, item_q.column} < MAXC) begin
							rd_en = 1'b1;
							rd_addr = item_q.column[AW-1:0];
						end
						state_d = wclb_pkg::ST_RDCELL;
					end
					default: ;
				endcase
			end
			wclb_pkg::ST_RD1: begin
				k0_d = wclb_pkg::KIND_SINGLE;
				if (col < MAXC) begin
					rd_en = 1'b1;
					rd_addr = AW'(col);
				end
				state_d = wclb_pkg::ST_RD2;
			end
			wclb_pkg::ST_RD2: begin
				if (col + 10'd1 < MAXC) begin
					rd_en = 1'b1;
					rd_addr = AW'(col + 10'd1);
				end
				state_d = wclb_pkg::ST_PLAN;
			end
			wclb_pkg::ST_PLAN: begin
				// kind of col+1 arrives now on rd_data
				state_d = wclb_pkg::ST_WR;
				wv_d = '0;
				for (int i = 0; i < 4; i++) begin
					wa_d[i] = '0;
					wd_d[i] = blank;
				end
				if (item_q.cmd == wclb_pkg::CMD_ERASE) begin
					// k0 read in RD1 landed in RD2; kept in k0_q by the RD2 assignment after the case
					if (k0_q == wclb_pkg::KIND_SECOND && col != 10'd0) begin
						wv_d[0] = 1'b1;
						wa_d[0] = col - 10'd1;
					end
					sw_d = col;
					swe_d = w_eff;
				end else if (wide_q) begin
					lead_d = '0;
					cursor_d = (adv2 > 9'd255) ? 8'hFF : adv2[7:0];
					if (col + 10'd2 > w_eff) begin
						if (col + 10'd1 == w_eff) begin
							if (k0_q == wclb_pkg::KIND_SECOND && col != 10'd0) begin
								wv_d[0] = 1'b1;
								wa_d[0] = col - 10'd1;
							end
							wv_d[1] = 1'b1;
							wa_d[1] = col;
						end
					end else begin
						if (k0_q == wclb_pkg::KIND_SECOND && col != 10'd0) begin
							wv_d[0] = 1'b1;
							wa_d[0] = col - 10'd1;
						end
						if (k0_q != wclb_pkg::KIND_FIRST && rd_data[1:0] == wclb_pkg::KIND_FIRST
								&& col + 10'd1 < MAXC) begin
							wv_d[1] = 1'b1;
							wa_d[1] = col + 10'd2;
						end
						wv_d[2] = 1'b1;
						wa_d[2] = col;
						wd_d[2] = {wcode_q[15:8],
							(wcode_q == wclb_pkg::WIDE_SPACE) ? wsattr_q : nattr_q,
							wclb_pkg::KIND_FIRST};
						wv_d[3] = 1'b1;
						wa_d[3] = col + 10'd1;
						wd_d[3] = {wcode_q[7:0],
							(wcode_q == wclb_pkg::WIDE_SPACE) ? wsattr_q : nattr_q,
							wclb_pkg::KIND_SECOND};
					end
				end else if (lead_byte) begin
					lead_d = ch_q;
				end else begin
					cursor_d = (adv1 > 9'd255) ? 8'hFF : adv1[7:0];
					if (col < w_eff) begin
						if (k0_q == wclb_pkg::KIND_SECOND && col != 10'd0) begin
							wv_d[0] = 1'b1;
							wa_d[0] = col - 10'd1;
						end else if (k0_q == wclb_pkg::KIND_FIRST) begin
							wv_d[0] = 1'b1;
							wa_d[0] = col + 10'd1;
						end
						wv_d[2] = 1'b1;
						wa_d[2] = col;
						wd_d[2] = {ch_q, nattr_q, wclb_pkg::KIND_SINGLE};
					end
				end
			end
			wclb_pkg::ST_WR: begin
				if (wv_q[0]) widx = 3'd0;
				else if (wv_q[1]) widx = 3'd1;
				else if (wv_q[2]) widx = 3'd2;
				else if (wv_q[3]) widx = 3'd3;
				else widx = 3'd4;
				if (widx != 3'd4) begin
					wr_en = (wa_q[widx[1:0]] < MAXC);
					wr_addr = AW'(wa_q[widx[1:0]]);
					wr_data = wd_q[widx[1:0]];
					wv_d[widx[1:0]] = 1'b0;
				end else if (item_q.cmd == wclb_pkg::CMD_ERASE) begin
					state_d = wclb_pkg::ST_SWEEP;
				end else if (caret_q) begin
					state_d = wclb_pkg::ST_DISP;
				end else begin
					state_d = wclb_pkg::ST_DONE;
				end
			end
			wclb_pkg::ST_SWEEP: begin
				if (sw_q < swe_q) begin
					wr_en = 1'b1;
					wr_addr = AW'(sw_q);
					wr_data = blank;
					sw_d = sw_q + 10'd1;
				end else begin
					state_d = wclb_pkg::ST_DONE;
				end
			end
			wclb_pkg::ST_RDCELL: begin
				res_d.cursor_col = cursor_q;
				res_d.lead_pending = (lead_q != 8'd0);
				if ({2'b0, item_q.column} < MAXC) begin
					res_d.cell_code = rd_data[17:10];
					res_d.cell_attr = rd_data[9:2];
					res_d.cell_kind = rd_data[1:0];
				end else begin
					res_d.cell_code = wclb_pkg::BLANK_CODE;
					res_d.cell_attr = nattr_q;
					res_d.cell_kind = wclb_pkg::KIND_SINGLE;
				end
				done_d = 1'b1;
				state_d = wclb_pkg::ST_IDLE;
			end
			wclb_pkg::ST_DONE: begin
				res_d.cursor_col = cursor_q;
				res_d.lead_pending = (lead_q != 8'd0);
				res_d.cell_code = '0;
				res_d.cell_attr = '0;
				res_d.cell_kind = '0;
				done_d = 1'b1;
				state_d = wclb_pkg::ST_IDLE;
			end
			default: state_d = wclb_pkg::ST_IDLE;
		endcase

		// kind of col lands in the cycle after RD1
		if (state_q == wclb_pkg::ST_RD2 && col < MAXC) k0_d = rd_data[1:0];
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == wclb_pkg::ST_IDLE)
		else $error("result strobe outside idle");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("double result strobe");
	a_start_taken: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item not taken");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wclb_pkg::ST_SWEEP && wr_en |-> sw_q < MAXC)
		else $error("sweep past store");
`endif

endmodule
`default_nettype wire

// File: verif/tb_wide_char_line_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_wide_char_line_buffer: self-checking bench for the wide character line buffer
// Runs directed and random commands through the buffer. An in-bench line model
// predicts each result, and the result is compared field by field.
// ----------------------------------------------------------------------------
module tb_wide_char_line_buffer;

	localparam int NCOL = wclb_pkg::MAX_COLUMNS_DEF;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	wclb_pkg::in_item_t item = '0;
	logic done;
	wclb_pkg::out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	wide_char_line_buffer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// line model state
	logic [7:0] m_code [NCOL];
	logic [7:0] m_attr [NCOL];
	wclb_pkg::kind_t m_kind [NCOL];
	logic [7:0] m_cursor, m_lead;
	logic [7:0] r_width, r_nattr, r_wsattr;
	logic r_dispen;

	wclb_pkg::out_item_t expected_q[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int idle_pct = 0;
	longint cycles = 0;

	function automatic int line_w();
		int w;
		w = r_width;
		if (w < 1) w = 1;
		if (w > NCOL) w = NCOL;
		return w;
	endfunction

	function automatic void write_cell(int i, logic [7:0] c, logic [7:0] a,
			wclb_pkg::kind_t k);
		if (i < NCOL) begin
			m_code[i] = c;
			m_attr[i] = a;
			m_kind[i] = k;
		end
	endfunction

	function automatic void blank_at(int i);
		write_cell(i, wclb_pkg::BLANK_CODE, r_nattr, wclb_pkg::KIND_SINGLE);
	endfunction

	function automatic wclb_pkg::kind_t kind_of(int i);
		return (i < NCOL) ? m_kind[i] : wclb_pkg::KIND_SINGLE;
	endfunction

	function automatic logic [7:0] step_col(int col, int n);
		return (col + n > 255) ? 8'd255 : 8'(col + n);
	endfunction

	function automatic bit lead_byte(int c);
		return (c >= 'h81 && c <= 'h9F) || (c >= 'hE0 && c <= 'hFC);
	endfunction

	function automatic void place_glyph(int c);
		int col, w;
		logic [7:0] a;
		col = m_cursor;
		w = line_w();
		if (m_lead != 0 || c > 'hFF) begin
			a = r_nattr;
			if (m_lead != 0) begin
				c = (int'(m_lead) << 8) | (c & 'hFF);
				m_lead = 0;
			end
			if (col + 2 > w) begin
				if (col + 1 == w) begin
					if (kind_of(col) == wclb_pkg::KIND_SECOND && col > 0) blank_at(col - 1);
					blank_at(col);
				end
				m_cursor = step_col(col, 2);
				return;
			end
			if (kind_of(col) == wclb_pkg::KIND_SECOND && col > 0) blank_at(col - 1);
			if (kind_of(col) != wclb_pkg::KIND_FIRST
					&& kind_of(col + 1) == wclb_pkg::KIND_FIRST) begin
				blank_at(col + 1);
				blank_at(col + 2);
			end
			if (c == wclb_pkg::WIDE_SPACE) a = r_wsattr;
			write_cell(col, 8'(c >> 8), a, wclb_pkg::KIND_FIRST);
			write_cell(col + 1, 8'(c), a, wclb_pkg::KIND_SECOND);
			m_cursor = step_col(col, 2);
			return;
		end
		if (lead_byte(c)) begin
			m_lead = 8'(c);
			return;
		end
		if (col < w) begin
			if (kind_of(col) == wclb_pkg::KIND_SECOND) begin
				if (col > 0) blank_at(col - 1);
			end else if (kind_of(col) == wclb_pkg::KIND_FIRST) begin
				blank_at(col + 1);
			end
			write_cell(col, 8'(c), r_nattr, wclb_pkg::KIND_SINGLE);
		end
		m_cursor = step_col(col, 1);
	endfunction

	function automatic wclb_pkg::out_item_t predict_line(wclb_pkg::in_item_t it);
		wclb_pkg::out_item_t r;
		int c, col, w;
		r = '0;
		c = it.code;
		case (it.cmd)
			wclb_pkg::CMD_PUT: begin
				if (c == wclb_pkg::BS_CODE) begin
					if (m_cursor > 0) m_cursor--;
				end else if (c == wclb_pkg::FF_CODE) begin
					m_cursor = step_col(m_cursor, 1);
				end else if (c < wclb_pkg::BLANK_CODE) begin
					place_glyph(wclb_pkg::CARET);
					place_glyph(c + wclb_pkg::AT_SIGN);
				end else begin
					place_glyph(c);
				end
			end
			wclb_pkg::CMD_SETC: m_cursor = it.column;
			wclb_pkg::CMD_CLEAR: begin
				m_lead = 0;
				m_cursor = 0;
				if (r_dispen) for (int i = 0; i < line_w(); i++) blank_at(i);
			end
			wclb_pkg::CMD_ERASE: begin
				col = m_cursor;
				w = line_w();
				if (col <= w) begin
					if (kind_of(col) == wclb_pkg::KIND_SECOND && col > 0) blank_at(col - 1);
					for (int i = col; i < w; i++) blank_at(i);
				end
			end
			wclb_pkg::CMD_READ: begin
				if (it.column < NCOL) begin
					r.cell_code = m_code[it.column];
					r.cell_attr = m_attr[it.column];
					r.cell_kind = m_kind[it.column];
				end else begin
					r.cell_code = wclb_pkg::BLANK_CODE;
					r.cell_attr = r_nattr;
					r.cell_kind = wclb_pkg::KIND_SINGLE;
				end
			end
			default: ;
		endcase
		r.cursor_col = m_cursor;
		r.lead_pending = (m_lead != 0);
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		wclb_pkg::out_item_t e;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", result);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result.cursor_col !== e.cursor_col) begin
					$error("cursor_col exp %0d got %0d", e.cursor_col, result.cursor_col);
					errors++;
				end
				if (result.cell_code !== e.cell_code) begin
					$error("cell_code exp %h got %h", e.cell_code, result.cell_code);
					errors++;
				end
				if (result.cell_attr !== e.cell_attr) begin
					$error("cell_attr exp %h got %h", e.cell_attr, result.cell_attr);
					errors++;
				end
				if (result.cell_kind !== e.cell_kind) begin
					$error("cell_kind exp %0d got %0d", e.cell_kind, result.cell_kind);
					errors++;
				end
				if (result.lead_pending !== e.lead_pending) begin
					$error("lead_pending exp %0d got %0d", e.lead_pending,
						result.lead_pending);
					errors++;
				end
			end
		end
	end

	// start stays high between back-to-back items; it drops for idle gaps and in drain()
	task automatic send_item(wclb_pkg::cmd_t cmd, logic [15:0] code, logic [7:0] column);
		wclb_pkg::in_item_t it;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		it.cmd = cmd;
		it.code = code;
		it.column = column;
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(predict_line(it));
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(wclb_pkg::reg_idx_t idx, logic [7:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			wclb_pkg::REG_WIDTH: r_width = data;
			wclb_pkg::REG_NATTR: r_nattr = data;
			wclb_pkg::REG_WSATTR: r_wsattr = data;
			default: r_dispen = data[0];
		endcase
	endtask

	function automatic logic [15:0] rand_code();
		int s;
		s = $urandom_range(99);
		if (s < 35) return 16'($urandom_range('h20, 'h7E));
		if (s < 50) return 16'($urandom_range(0, 'h1F));
		if (s < 65) return $urandom_range(1) ? 16'($urandom_range('h81, 'h9F))
			: 16'($urandom_range('hE0, 'hFC));
		if (s < 75) return 16'($urandom_range('h80, 'hFF));
		if (s < 80) return wclb_pkg::WIDE_SPACE;
		return 16'($urandom);
	endfunction

	task automatic test_directed();
		send_item(wclb_pkg::CMD_PUT, 16'h0041, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h0000, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h001F, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h0081, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h0008, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h000C, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h0001, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h00FC, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h00FF, 8'd0);
		send_item(wclb_pkg::CMD_PUT, wclb_pkg::WIDE_SPACE, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'hFFFF, 8'd0);
		send_item(wclb_pkg::CMD_SETC, 16'd0, 8'd1);
		send_item(wclb_pkg::CMD_PUT, 16'h0042, 8'd0);
		send_item(wclb_pkg::CMD_SETC, 16'd0, 8'd79);
		send_item(wclb_pkg::CMD_PUT, 16'h889F, 8'd0);
		send_item(wclb_pkg::CMD_SETC, 16'd0, 8'd254);
		send_item(wclb_pkg::CMD_PUT, 16'h889F, 8'd0);
		send_item(wclb_pkg::CMD_PUT, 16'h0043, 8'd0);
		send_item(wclb_pkg::CMD_ERASE, 16'd0, 8'd0);
		send_item(wclb_pkg::CMD_READ, 16'd0, 8'd255);
		send_item(wclb_pkg::CMD_READ, 16'd0, 8'd127);
		send_item(wclb_pkg::cmd_t'(3'd7), 16'hFFFF, 8'hFF);
		send_item(wclb_pkg::cmd_t'(3'd5), 16'd0, 8'd0);
		send_item(wclb_pkg::CMD_CLEAR, 16'd0, 8'd0);
		for (int i = 0; i < 4; i++) send_item(wclb_pkg::CMD_READ, 16'd0, 8'(i));
	endtask

	task automatic test_random(int n);
		int s;
		logic [7:0] col;
		for (int i = 0; i < n; i++) begin
			s = $urandom_range(99);
			col = ($urandom_range(9) == 0) ? 8'($urandom)
				: 8'($urandom_range(0, line_w() + 2));
			if (s < 60) send_item(wclb_pkg::CMD_PUT, rand_code(), 8'($urandom));
			else if (s < 70) send_item(wclb_pkg::CMD_SETC, 16'($urandom), col);
			else if (s < 73) send_item(wclb_pkg::CMD_CLEAR, 16'($urandom), 8'($urandom));
			else if (s < 78) send_item(wclb_pkg::CMD_ERASE, 16'($urandom), 8'($urandom));
			else if (s < 97) send_item(wclb_pkg::CMD_READ, 16'($urandom), col);
			else send_item(wclb_pkg::cmd_t'($urandom_range(5, 7)), 16'($urandom),
				8'($urandom));
		end
	endtask

	task automatic test_settings();
		int pct[4] = '{0, 85, 0, 26};
		logic [7:0] widths[5] = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd5};
		for (int p = 0; p < 5; p++) begin
			idle_pct = pct[p % 4];
			write_reg(wclb_pkg::REG_WIDTH, widths[p]);
			write_reg(wclb_pkg::REG_NATTR, (p == 1) ? 8'hFF : 8'($urandom));
			write_reg(wclb_pkg::REG_WSATTR, (p == 2) ? 8'h00 : 8'($urandom));
			write_reg(wclb_pkg::REG_DISPEN, (p == 3) ? 8'h00 : 8'($urandom));
			test_random(p == 0 ? 200 : 250);
		end
		idle_pct = 0;
		write_reg(wclb_pkg::REG_WIDTH, 8'd40);
		write_reg(wclb_pkg::REG_DISPEN, 8'h01);
		test_random(250);
	endtask

	initial begin
		for (int i = 0; i < NCOL; i++) begin
			m_code[i] = wclb_pkg::BLANK_CODE;
			m_attr[i] = wclb_pkg::RST_ATTR;
			m_kind[i] = wclb_pkg::KIND_SINGLE;
		end
		m_cursor = 0;
		m_lead = 0;
		r_width = wclb_pkg::RST_WIDTH;
		r_nattr = wclb_pkg::RST_ATTR;
		r_wsattr = wclb_pkg::RST_ATTR;
		r_dispen = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100);
		test_settings();
		drain();
		$display("Sent %0d items over widths 0..255, attribute and display settings;",
			items_sent);
		$display("%0d results checked, with idle rates of 0, 26 and 85 percent.",
			results_seen);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
